// ----- hdl/gtl_pkg.sv -----
// Package for the grid tile layout block: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gtl_pkg;

    // Controller states
    typedef enum logic [3:0] {
        t_s_idle,
        t_s_grid,
        t_s_div_h,
        t_s_div_w,
        t_s_check,
        t_s_div_rs,
        t_s_div_ci,
        t_s_mul,
        t_s_out,
        t_s_wait
    } t_state;

    // Divider operand select
    typedef enum logic [1:0] {
        t_div_cell_h,
        t_div_cell_w,
        t_div_resplit,
        t_div_index
    } t_div_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic     grid_step;
        logic     div_start;
        t_div_sel div_sel;
        logic     load_cell_h;
        logic     load_cell_w;
        logic     load_colrow;
        logic     mul_step;
        logic     load_out;
        logic     advance;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic grid_done;
        logic div_done;
        logic tile_ok;
        logic resplit;
    } t_status;

    // Register indexes
    localparam logic [2:0] REG_AREA_X = 3'd0;
    localparam logic [2:0] REG_AREA_Y = 3'd1;
    localparam logic [2:0] REG_AREA_W = 3'd2;
    localparam logic [2:0] REG_AREA_H = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;

endpackage
`default_nettype wire

// ----- hdl/grid_tile_layout.sv -----
// Top level of the grid tile layout block: APB registers, controller, datapath.
// Depends on gtl_pkg, gtl_ctrl, gtl_dp.
`timescale 1ns / 1ps
`default_nettype none
// Each item is one window; items are taken one at a time. A tiled window
// goes from acceptance in the idle state through a check state, one
// divide for the index split, a multiply state and the output load, and
// back to idle, which takes the next item. When the short last row is
// re-split, a second divide comes before the index split. An item with
// first set first runs the column search, trying column counts in turn
// until their square reaches the window count (8 columns for 64 windows),
// and two divides for the cell height and width. Minimized windows, and
// windows that get no tile, go from the check state back to idle with no
// result. An untaken result holds the block until the output register frees.
module grid_tile_layout
    import gtl_pkg::*;
#(
    parameter int MAX_WINDOWS = 64,
    parameter int COORD_BITS  = 12
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_first,
    input  wire         i_minimized,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [11:0] o_win_x,
    output logic [11:0] o_win_y,
    output logic [11:0] o_win_w,
    output logic [11:0] o_win_h,
    output logic        o_has_border,
    output logic [11:0] o_border_x,
    output logic [11:0] o_border_y,
    output logic [11:0] o_border_len,
    output logic        o_junction,
    output logic        o_last
);
    logic [11:0] r_area_x, r_area_y, r_area_w, r_area_h;
    logic [6:0]  r_count;
    logic        r_valid;
    logic        w_out_free;
    t_cmd        w_cmd;
    t_status     w_status;
    logic [2:0]  w_reg;

    assign pready = 1'b1;
    assign w_reg  = paddr[4:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_x <= 12'd0;
            r_area_y <= 12'd1;
            r_area_w <= 12'd80;
            r_area_h <= 12'd24;
            r_count  <= 7'd0;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_AREA_X: r_area_x <= pwdata[11:0];
                REG_AREA_Y: r_area_y <= pwdata[11:0];
                REG_AREA_W: r_area_w <= pwdata[11:0];
                REG_AREA_H: r_area_h <= pwdata[11:0];
                REG_COUNT:  r_count  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (w_reg)
            REG_AREA_X: prdata = {20'd0, r_area_x};
            REG_AREA_Y: prdata = {20'd0, r_area_y};
            REG_AREA_W: prdata = {20'd0, r_area_w};
            REG_AREA_H: prdata = {20'd0, r_area_h};
            REG_COUNT:  prdata = {25'd0, r_count};
            default:    prdata = 32'd0;
        endcase
    end

    // Output valid: set on load, drop when taken
    assign w_out_free = !r_valid || i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_cmd.load_out) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end
    assign o_valid = r_valid;

    gtl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_first     (i_first),
        .i_minimized (i_minimized),
        .i_out_free  (w_out_free),
        .i_status    (w_status),
        .o_ready     (o_ready),
        .o_cmd       (w_cmd)
    );

    gtl_dp #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_area_x     (r_area_x),
        .i_area_y     (r_area_y),
        .i_area_w     (r_area_w),
        .i_area_h     (r_area_h),
        .i_count      (r_count),
        .o_status     (w_status),
        .o_win_x      (o_win_x),
        .o_win_y      (o_win_y),
        .o_win_w      (o_win_w),
        .o_win_h      (o_win_h),
        .o_has_border (o_has_border),
        .o_border_x   (o_border_x),
        .o_border_y   (o_border_y),
        .o_border_len (o_border_len),
        .o_junction   (o_junction),
        .o_last       (o_last)
    );
endmodule
`default_nettype wire

// ----- hdl/gtl_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module gtl_div #(
    parameter int W = 12
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire [W-1:0]  i_num,
    input  wire [W-1:0]  i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [W:0]    w_trial;

    // One shift-subtract step
    always_comb begin
        w_trial = {r_rem, r_quo[W-1]};
        n_quo   = {r_quo[W-2:0], 1'b0};
        n_rem   = w_trial[W-1:0];
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem    = W'(w_trial - {1'b0, r_den});
                n_quo[0] = 1'b1;
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end else begin
            n_quo = r_quo;
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    // Done depends on state only, so a start may follow it in the same cycle
    assign o_done = !r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ----- hdl/gtl_ctrl.sv -----
// Controller state machine for the grid tile layout block.
// Depends on gtl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gtl_ctrl
    import gtl_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_valid,
    input  wire      i_first,
    input  wire      i_minimized,
    input  wire      i_out_free,
    input  t_status  i_status,
    output logic     o_ready,
    output t_cmd     o_cmd
);
    t_state r_state, n_state;
    logic   r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_s_idle;
        end else begin
            r_state <= n_state;
        end
    end

    // Remember the minimized flag of the item in work
    always_ff @(posedge i_clk) begin
        if (r_state == t_s_idle && i_valid) begin
            r_min <= i_minimized;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            t_s_idle: begin
                if (i_valid) begin
                    n_state = i_first ? t_s_grid : t_s_check;
                end
            end
            t_s_grid: begin
                if (i_status.grid_done) begin
                    n_state = t_s_div_h;
                end
            end
            t_s_div_h: begin
                if (i_status.div_done) begin
                    n_state = t_s_div_w;
                end
            end
            t_s_div_w: begin
                if (i_status.div_done) begin
                    n_state = t_s_check;
                end
            end
            t_s_check: begin
                if (r_min || !i_status.tile_ok) begin
                    n_state = t_s_idle;
                end else if (i_status.resplit) begin
                    n_state = t_s_div_rs;
                end else begin
                    n_state = t_s_div_ci;
                end
            end
            t_s_div_rs: begin
                if (i_status.div_done) begin
                    n_state = t_s_div_ci;
                end
            end
            t_s_div_ci: begin
                if (i_status.div_done) begin
                    n_state = t_s_mul;
                end
            end
            t_s_mul:  n_state = t_s_out;
            t_s_out:  n_state = i_out_free ? t_s_idle : t_s_wait;
            t_s_wait: n_state = i_out_free ? t_s_idle : t_s_wait;
            default:  n_state = t_s_idle;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            t_s_idle: begin
                o_ready = 1'b1;
                o_cmd.grid_step = i_valid && i_first;
            end
            t_s_grid: begin
                o_cmd.grid_step = !i_status.grid_done;
                if (i_status.grid_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = t_div_cell_h;
                end
            end
            t_s_div_h: begin
                o_cmd.div_sel = t_div_cell_h;
                if (i_status.div_done) begin
                    o_cmd.load_cell_h = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel     = t_div_cell_w;
                end
            end
            t_s_div_w: begin
                o_cmd.div_sel = t_div_cell_w;
                o_cmd.load_cell_w = i_status.div_done;
            end
            t_s_check: begin
                if (!r_min && i_status.tile_ok) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = i_status.resplit ? t_div_resplit : t_div_index;
                end
            end
            t_s_div_rs: begin
                o_cmd.div_sel = t_div_resplit;
                if (i_status.div_done) begin
                    o_cmd.load_cell_w = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel     = t_div_index;
                end
            end
            t_s_div_ci: begin
                o_cmd.div_sel = t_div_index;
                o_cmd.load_colrow = i_status.div_done;
            end
            t_s_mul: o_cmd.mul_step = 1'b1;
            t_s_out: begin
                o_cmd.load_out = i_out_free;
                o_cmd.advance  = i_out_free;
            end
            t_s_wait: begin
                o_cmd.load_out = i_out_free;
                o_cmd.advance  = i_out_free;
            end
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/gtl_dp.sv -----
// Datapath for the grid tile layout block: grid search, divider, tile math.
// Depends on gtl_pkg and gtl_div.
`timescale 1ns / 1ps
`default_nettype none
module gtl_dp
    import gtl_pkg::*;
#(
    parameter int MAX_WINDOWS = 64,
    parameter int COORD_BITS  = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    input  wire [11:0]           i_area_x,
    input  wire [11:0]           i_area_y,
    input  wire [11:0]           i_area_w,
    input  wire [11:0]           i_area_h,
    input  wire [6:0]            i_count,
    output t_status              o_status,
    output logic [11:0]          o_win_x,
    output logic [11:0]          o_win_y,
    output logic [11:0]          o_win_w,
    output logic [11:0]          o_win_h,
    output logic                 o_has_border,
    output logic [11:0]          o_border_x,
    output logic [11:0]          o_border_y,
    output logic [11:0]          o_border_len,
    output logic                 o_junction,
    output logic                 o_last
);
    localparam int NB = $clog2(MAX_WINDOWS + 1) > 7 ? $clog2(MAX_WINDOWS + 1) : 7;
    localparam int DW = 12;
    localparam int SW = 26;

    logic [NB-1:0] w_n;
    logic [3:0]    r_cols, r_rows;
    logic [4:0]    r_c;
    logic [NB-1:0] r_idx;
    logic [11:0]   r_cell_w, r_cell_h;
    logic [11:0]   r_col, r_row;
    logic [11:0]   r_rem;
    logic [SW-1:0] r_x, r_y, r_nwr, r_nhr, r_nwc;
    logic [DW-1:0] w_num, w_den, w_quo, w_rmd;
    logic          w_div_done;

    // Saturate the window count
    assign w_n = ({{(NB-7){1'b0}}, i_count} > NB'(MAX_WINDOWS)) ?
                 NB'(MAX_WINDOWS) : {{(NB-7){1'b0}}, i_count};

    // Grid search: grow c until c*c reaches n
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c    <= '0;
            r_cols <= '0;
            r_rows <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.grid_step) begin
                if (o_status.grid_done) begin
                    r_c <= '0;
                end else begin
                    r_c <= r_c + 5'd1;
                end
            end
            if (o_status.grid_done && i_cmd.div_start &&
                i_cmd.div_sel == t_div_cell_h) begin
                r_cols <= r_c[3:0];
                r_rows <= (r_c != 5'd0 && 10'((r_c - 5'd1) * r_c) >= 10'(w_n)) ?
                          4'(r_c - 5'd1) : r_c[3:0];
                r_idx  <= '0;
                r_c    <= '0;
            end
            if (i_cmd.advance) begin
                r_idx <= r_idx + NB'(1);
            end
        end
    end

    logic [4:0] w_rows_new;
    assign w_rows_new = (r_c != 5'd0 && 10'((r_c - 5'd1) * r_c) >= 10'(w_n)) ?
                        (r_c - 5'd1) : r_c;

    assign o_status.grid_done = 10'(r_c * r_c) >= 10'(w_n);

    // Start index of the last row (rows*cols - cols) and last-window flag
    logic [NB-1:0] w_lrs;
    logic          w_last_i;
    assign w_lrs    = NB'(r_rows * r_cols) - NB'(r_cols);
    assign w_last_i = (r_idx == w_n - NB'(1));

    // Divider operands
    always_comb begin
        case (i_cmd.div_sel)
            t_div_cell_h: begin
                w_num = i_area_h;
                w_den = (w_rows_new == 5'd0) ? DW'(1) : DW'(w_rows_new);
            end
            t_div_cell_w: begin
                w_num = i_area_w;
                w_den = (r_cols == 4'd0) ? DW'(1) : DW'(r_cols);
            end
            t_div_resplit: begin
                w_num = i_area_w;
                w_den = DW'(w_n - r_idx);
            end
            t_div_index: begin
                w_num = DW'(r_idx);
                w_den = DW'(r_cols);
            end
            default: begin
                w_num = '0;
                w_den = DW'(1);
            end
        endcase
    end

    gtl_div #(.W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rmd)
    );
    assign o_status.div_done = w_div_done;

    // n mod cols: n - cols*(n/cols) via small loop-free compare (n < 17*cols, cols<=15)
    logic [11:0] w_nrem;
    always_comb begin
        w_nrem = '0;
        for (int k = 0; k < 17; k++) begin
            if (r_cols != 4'd0 && 12'(w_n) >= 12'(k * r_cols) &&
                12'(w_n) < 12'((k + 1) * r_cols)) begin
                w_nrem = 12'(w_n) - 12'(k * r_cols);
            end
        end
    end

    assign o_status.tile_ok = (r_cols != 4'd0) && (r_idx < w_n);
    assign o_status.resplit = (r_rows > 4'd1) && (r_idx == w_lrs) &&
                              (12'(w_n - r_idx) <= w_nrem);

    // Cell size and index split
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w <= '0;
            r_cell_h <= '0;
        end else begin
            if (i_cmd.load_cell_h) r_cell_h <= w_quo;
            if (i_cmd.load_cell_w) r_cell_w <= w_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_colrow) begin
            r_col <= w_rmd;
            r_row <= w_quo;
            r_rem <= w_nrem;
        end
    end

    // Products, one register stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_step) begin
            r_x   <= SW'(r_col * r_cell_w) + SW'(i_area_x);
            r_y   <= SW'(r_row * r_cell_h) + SW'(i_area_y);
            r_nhr <= SW'(r_cell_h * r_rows);
            r_nwr <= SW'(r_cell_w * r_rem);
            r_nwc <= SW'(r_cell_w * r_cols);
        end
    end

    // Tile fields
    logic              w_border, w_plus, w_ah_on, w_aw_rem, w_aw_col;
    logic signed [SW:0] w_h, w_w;
    logic [11:0]       w_col1;
    assign w_border = (r_col != 12'd0);
    assign w_ah_on  = (12'(r_idx) >= 12'(r_cols * (r_rows - 4'd1)));
    assign w_aw_rem = (r_rows > 4'd1) && w_last_i && (r_rem > 12'd1);
    assign w_col1   = r_col + 12'd1;
    assign w_aw_col = (w_col1 == 12'(r_cols));
    assign w_plus   = !((12'(r_idx) <= 12'(r_cols)) ||
                        ((r_idx >= w_lrs) && (r_rem != 12'd0) &&
                         ((12'(r_cols) - r_rem) % 2 != 0)));

    always_comb begin
        w_h = $signed({1'b0, SW'(r_cell_h)});
        if (w_ah_on) begin
            w_h = $signed({1'b0, SW'(r_cell_h)}) + $signed({1'b0, SW'(i_area_h)})
                  - $signed({1'b0, r_nhr});
        end
        w_w = $signed({1'b0, SW'(r_cell_w)});
        if (w_aw_rem) begin
            w_w = w_w + $signed({1'b0, SW'(i_area_w)}) - $signed({1'b0, r_nwr});
        end else if (w_aw_col) begin
            w_w = w_w + $signed({1'b0, SW'(i_area_w)}) - $signed({1'b0, r_nwc});
        end
        if (w_border) begin
            w_w = w_w - (SW+1)'(1);
        end
    end

    logic [11:0] w_hc, w_wc;
    assign w_hc = w_h[SW] ? 12'd0 : w_h[11:0];
    assign w_wc = w_w[SW] ? 12'd0 : w_w[11:0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_win_x      <= 12'(COORD_BITS'(r_x + SW'(w_border)));
            o_win_y      <= 12'(COORD_BITS'(r_y));
            o_win_w      <= w_wc;
            o_win_h      <= w_hc;
            o_has_border <= w_border;
            o_border_x   <= w_border ? 12'(COORD_BITS'(r_x)) : 12'd0;
            o_border_y   <= w_border ? 12'(COORD_BITS'(r_y - SW'(1))) : 12'd0;
            o_border_len <= w_border ? w_hc : 12'd0;
            o_junction   <= w_border && w_plus;
            o_last       <= w_last_i;
        end
    end
endmodule
`default_nettype wire
